// File: rtl/assert_macros.svh
// Assertion macros for the traceparent parser RTL; only the parser core includes them.
// Depends on nothing; the user module supplies clk and rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked outside reset
`define TPP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked in every cycle, reset included
`define TPP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/tpp_pkg.sv
// Package for the traceparent parser: item types, error codes, positions and
// the character decode function. No dependencies.
package tpp_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic        header_ok;
    logic [2:0]  error_code;
    logic [63:0] trace_id_upper;
    logic [63:0] trace_id_lower;
    logic [63:0] span_id;
    logic [7:0]  trace_flags;
  } out_item_t;

  typedef enum logic [2:0] {
    ERR_OK         = 3'd0,
    ERR_LENGTH     = 3'd1,
    ERR_DASH       = 3'd2,
    ERR_VERSION    = 3'd3,
    ERR_HEX        = 3'd4,
    ERR_ZERO_TRACE = 3'd5,
    ERR_ZERO_SPAN  = 3'd6
  } err_code_t;

  localparam logic [5:0] HDR_LEN        = 6'd55;
  localparam logic [5:0] HDR_LAST       = 6'd54;
  localparam logic [5:0] POS_SAT        = 6'd56;
  localparam logic [5:0] DASH_A         = 6'd2;
  localparam logic [5:0] DASH_B         = 6'd35;
  localparam logic [5:0] DASH_C         = 6'd52;
  localparam logic [5:0] TRACE_LO_START = 6'd19;

  localparam logic [7:0] CHAR_DASH = 8'h2d;
  localparam logic [7:0] CHAR_ZERO = 8'h30;

  typedef struct packed {
    logic       is_hex;
    logic [3:0] nibble;
  } char_info_t;

  function automatic char_info_t decode_char(input logic [7:0] c);
    char_info_t r;
    r.is_hex = 1'b0;
    r.nibble = 4'd0;
    if (c inside {[8'h30:8'h39]}) begin
      r.is_hex = 1'b1;
      r.nibble = c[3:0];
    end else if (c inside {[8'h61:8'h66]}) begin
      r.is_hex = 1'b1;
      r.nibble = c[3:0] + 4'd9;
    end
    return r;
  endfunction

endpackage

// File: rtl/traceparent_header_parser_core.sv
// Traceparent header parser: one byte item per cycle in, one result item
// after the final byte. The final byte is held in the input register, then its
// verdict is loaded into the result register, which raises res_valid.
// Throughput: 1 byte per cycle; stalls only while a result waits and the
// next final byte arrives. Synchronous active-high rst clears the valid flags and the parse state.
// Depends on tpp_pkg, tpp_accum, tpp_result_reg, assert_macros.svh.
`include "assert_macros.svh"
module traceparent_header_parser_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               hdr_valid,
  output logic               hdr_ready,
  input  tpp_pkg::in_item_t  hdr_item,
  output logic               res_valid,
  input  logic               res_ready,
  output tpp_pkg::out_item_t res_item
);
  import tpp_pkg::*;

  logic      s1_valid;
  in_item_t  s1_item;
  logic      s1_fire;
  out_item_t verdict;

  // a final byte waits until the result register is free
  assign s1_fire   = s1_valid && (!s1_item.last_byte || !res_valid || res_ready);
  assign hdr_ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (hdr_ready) begin
      s1_valid <= hdr_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (hdr_valid && hdr_ready) begin
      s1_item <= hdr_item;
    end
  end

  tpp_accum u_accum (
    .clk     (clk),
    .rst     (rst),
    .step    (s1_fire),
    .item    (s1_item),
    .verdict (verdict)
  );

  tpp_result_reg u_result (
    .clk       (clk),
    .rst       (rst),
    .load      (s1_fire && s1_item.last_byte),
    .load_item (verdict),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item)
  );

  `TPP_ASSERT_ALWAYS(a_rst_clears, rst |=> !res_valid && hdr_ready, "reset left an item pending")
  `TPP_ASSERT(a_ok_code, res_valid |-> res_item.header_ok == (res_item.error_code == ERR_OK), "ok flag and code disagree")
  `TPP_ASSERT(a_bad_zero, res_valid && !res_item.header_ok |-> res_item.span_id == 64'd0 && res_item.trace_flags == 8'd0, "fields not cleared on bad header")
  `TPP_ASSERT(a_no_overwrite, res_valid && !res_ready |=> !$past(s1_fire && s1_item.last_byte), "result overwritten while held")

endmodule

// File: rtl/tpp_accum.sv
// Per-header state: byte position, sticky faults, hex accumulators, and the
// verdict built from the next state on the final byte. Depends on tpp_pkg.
module tpp_accum (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  tpp_pkg::in_item_t item,
  output tpp_pkg::out_item_t verdict
);
  import tpp_pkg::*;

  logic [5:0]  byte_position, byte_position_next;
  logic        dash_fault, dash_fault_next;
  logic        version_fault, version_fault_next;
  logic        hex_fault, hex_fault_next;
  logic [63:0] trace_upper_acc, trace_upper_acc_next;
  logic [63:0] trace_lower_acc, trace_lower_acc_next;
  logic [63:0] span_acc, span_acc_next;
  logic [7:0]  flags_acc, flags_acc_next;
  char_info_t  ci;
  err_code_t   code;

  assign ci = decode_char(item.data_byte);

  always_comb begin
    dash_fault_next      = dash_fault;
    version_fault_next   = version_fault;
    hex_fault_next       = hex_fault;
    trace_upper_acc_next = trace_upper_acc;
    trace_lower_acc_next = trace_lower_acc;
    span_acc_next        = span_acc;
    flags_acc_next       = flags_acc;
    byte_position_next   = (byte_position < POS_SAT) ? byte_position + 6'd1 : byte_position;

    if (byte_position < DASH_A) begin
      if (item.data_byte != CHAR_ZERO) version_fault_next = 1'b1;
    end else if (byte_position == DASH_A || byte_position == DASH_B ||
                 byte_position == DASH_C) begin
      if (item.data_byte != CHAR_DASH) dash_fault_next = 1'b1;
    end else if (byte_position < HDR_LEN) begin
      if (!ci.is_hex) hex_fault_next = 1'b1;
      if (byte_position < TRACE_LO_START) begin
        trace_upper_acc_next = {trace_upper_acc[59:0], ci.nibble};
      end else if (byte_position < DASH_B) begin
        trace_lower_acc_next = {trace_lower_acc[59:0], ci.nibble};
      end else if (byte_position < DASH_C) begin
        span_acc_next = {span_acc[59:0], ci.nibble};
      end else begin
        flags_acc_next = {flags_acc[3:0], ci.nibble};
      end
    end

    if (byte_position != HDR_LAST) code = ERR_LENGTH;
    else if (dash_fault_next) code = ERR_DASH;
    else if (version_fault_next) code = ERR_VERSION;
    else if (hex_fault_next) code = ERR_HEX;
    else if (trace_upper_acc_next == 64'd0 && trace_lower_acc_next == 64'd0)
      code = ERR_ZERO_TRACE;
    else if (span_acc_next == 64'd0) code = ERR_ZERO_SPAN;
    else code = ERR_OK;

    verdict.header_ok      = (code == ERR_OK);
    verdict.error_code     = code;
    verdict.trace_id_upper = (code == ERR_OK) ? trace_upper_acc_next : 64'd0;
    verdict.trace_id_lower = (code == ERR_OK) ? trace_lower_acc_next : 64'd0;
    verdict.span_id        = (code == ERR_OK) ? span_acc_next : 64'd0;
    verdict.trace_flags    = (code == ERR_OK) ? flags_acc_next : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (rst || (step && item.last_byte)) begin
      byte_position   <= 6'd0;
      dash_fault      <= 1'b0;
      version_fault   <= 1'b0;
      hex_fault       <= 1'b0;
      trace_upper_acc <= 64'd0;
      trace_lower_acc <= 64'd0;
      span_acc        <= 64'd0;
      flags_acc       <= 8'd0;
    end else if (step) begin
      byte_position   <= byte_position_next;
      dash_fault      <= dash_fault_next;
      version_fault   <= version_fault_next;
      hex_fault       <= hex_fault_next;
      trace_upper_acc <= trace_upper_acc_next;
      trace_lower_acc <= trace_lower_acc_next;
      span_acc        <= span_acc_next;
      flags_acc       <= flags_acc_next;
    end
  end

endmodule

// File: rtl/tpp_result_reg.sv
// Output register holding one result item until the consumer takes it.
// Depends on tpp_pkg.
module tpp_result_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  tpp_pkg::out_item_t load_item,
  output logic               res_valid,
  input  logic               res_ready,
  output tpp_pkg::out_item_t res_item
);
  import tpp_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_item <= load_item;
    end
  end

endmodule

// File: tb/traceparent_header_parser_core_test.sv
// Self-checking testbench for traceparent_header_parser_core: directed header table,
// then random well-formed, damaged and noise headers, checked against a byte-level predictor.
// Depends on tpp_pkg and the parser RTL.
`timescale 1ns / 1ps
module traceparent_header_parser_core_test;
  import tpp_pkg::*;

  localparam int DIR_ROWS       = 21;
  localparam int RAND_BYTES     = 700;
  localparam int RAND_HEADERS   = 12;
  localparam int HOLD_CYCLES    = 400;
  localparam int SHORT_HEADERS  = 40;
  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PRINT_LIMIT    = 60;

  typedef struct packed {
    logic      pinned;
    out_item_t verdict;
  } row_verdict_t;

  typedef enum int {
    FLIP_RANDOM, FLIP_UPPER, FLIP_DASH, FLIP_ZERO, CUT_SHORT, RUN_LONG
  } damage_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      hdr_valid = 1'b0;
  logic      hdr_ready;
  in_item_t  hdr_item = '0;
  logic      res_valid;
  logic      res_ready = 1'b0;
  out_item_t res_item;

  traceparent_header_parser_core dut (
    .clk       (clk),
    .rst       (rst),
    .hdr_valid (hdr_valid),
    .hdr_ready (hdr_ready),
    .hdr_item  (hdr_item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // directed headers; pinned rows carry a hand-written error code
  string dir_text [DIR_ROWS] = '{
    "00-4bf92f3577b34da6a3ce929d0e0e4736-00f067aa0ba902b7-01",
    "00-ffffffffffffffffffffffffffffffff-ffffffffffffffff-ff",
    "00-00000000000000000000000000000001-0000000000000001-00",
    "00-09af09af09af09af09af09af09af09af-fa90fa90fa90fa90-9a",
    "00-00000000000000000000000000000000-00f067aa0ba902b7-01",
    "00-4bf92f3577b34da6a3ce929d0e0e4736-0000000000000000-01",
    "01-4bf92f3577b34da6a3ce929d0e0e4736-00f067aa0ba902b7-01",
    "f0-4bf92f3577b34da6a3ce929d0e0e4736-00f067aa0ba902b7-01",
    "00_4bf92f3577b34da6a3ce929d0e0e4736-00f067aa0ba902b7-01",
    "00-4bf92f3577b34da6a3ce929d0e0e4736+00f067aa0ba902b7-01",
    "00-4bf92f3577b34da6a3ce929d0e0e4736-00f067aa0ba902b7001",
    "00-4BF92F3577B34DA6A3CE929D0E0E4736-00f067aa0ba902b7-01",
    "00-/:@g2f3577b34da6a3ce929d0e0e4736-00f067aa0ba902b7-0g",
    "01_4bf92f3577b34da6a3ce929d0e0e4736-00f067aa0ba902b7-0G",
    "01-0000000000000000000000000000000g-00f067aa0ba902b7-01",
    "00-0000000000000000000000000000000g-00f067aa0ba902b7-01",
    "00-4bf92f3577b34da6a3ce929d0e0e4736-00f067aa0ba902b7-010",
    "00-4bf92f3577b34da6a3ce929d0e0e4736-00f067aa0ba902b7-0",
    "00-4bf92f3577b34da6a3ce929d0e0e4736-00f067aa0ba902b7-01zz-zzzzzzzz",
    "00_4bf",
    "0"
  };
  bit dir_pinned [DIR_ROWS] = '{
    1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
    1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1
  };
  err_code_t dir_code [DIR_ROWS] = '{
    ERR_OK, ERR_OK, ERR_OK, ERR_OK, ERR_ZERO_TRACE, ERR_ZERO_SPAN,
    ERR_VERSION, ERR_VERSION, ERR_DASH, ERR_DASH, ERR_DASH, ERR_HEX, ERR_HEX,
    ERR_DASH, ERR_VERSION, ERR_HEX, ERR_LENGTH, ERR_LENGTH, ERR_LENGTH,
    ERR_LENGTH, ERR_LENGTH
  };

  in_item_t     header_bytes[$];
  row_verdict_t fixed_verdicts[$];
  out_item_t    predicted_verdicts[$];
  logic [7:0]   draft[$];

  int bytes_queued;
  int bytes_taken;
  int headers_queued;
  int verdicts_seen;
  int mismatches;
  int idle_cycles;
  int code_hits [8];
  bit stall_request;
  bit stall_served;

  // parser state as the predictor tracks it
  logic [5:0]  cur_pos;
  logic        dash_bad;
  logic        ver_bad;
  logic        hex_bad;
  logic [63:0] acc_trace_hi;
  logic [63:0] acc_trace_lo;
  logic [63:0] acc_span;
  logic [7:0]  acc_flags;

  task automatic clear_parse_state();
    cur_pos      = '0;
    dash_bad     = 1'b0;
    ver_bad      = 1'b0;
    hex_bad      = 1'b0;
    acc_trace_hi = '0;
    acc_trace_lo = '0;
    acc_span     = '0;
    acc_flags    = '0;
  endtask

  task automatic parse_char(input in_item_t it, output bit done, output out_item_t verdict);
    logic [5:0] p;
    logic [7:0] c;
    logic [3:0] nib;
    err_code_t  code;
    p       = cur_pos;
    c       = it.data_byte;
    done    = it.last_byte;
    verdict = '0;
    if (p < HDR_LEN) begin
      if (p < DASH_A) begin
        if (c != CHAR_ZERO) ver_bad = 1'b1;
      end else if (p == DASH_A || p == DASH_B || p == DASH_C) begin
        if (c != CHAR_DASH) dash_bad = 1'b1;
      end else begin
        if (c >= "0" && c <= "9") begin
          nib = 4'(c - CHAR_ZERO);
        end else if (c >= "a" && c <= "f") begin
          nib = 4'(c - "a" + 10);
        end else begin
          nib = 4'd0;
          hex_bad = 1'b1;
        end
        if (p < TRACE_LO_START) acc_trace_hi = {acc_trace_hi[59:0], nib};
        else if (p < DASH_B) acc_trace_lo = {acc_trace_lo[59:0], nib};
        else if (p < DASH_C) acc_span = {acc_span[59:0], nib};
        else acc_flags = {acc_flags[3:0], nib};
      end
    end
    if (cur_pos < POS_SAT) cur_pos = cur_pos + 6'd1;
    if (done) begin
      if (p != HDR_LAST) code = ERR_LENGTH;
      else if (dash_bad) code = ERR_DASH;
      else if (ver_bad) code = ERR_VERSION;
      else if (hex_bad) code = ERR_HEX;
      else if (acc_trace_hi == '0 && acc_trace_lo == '0) code = ERR_ZERO_TRACE;
      else if (acc_span == '0) code = ERR_ZERO_SPAN;
      else code = ERR_OK;
      verdict.error_code = code;
      if (code == ERR_OK) begin
        verdict.header_ok      = 1'b1;
        verdict.trace_id_upper = acc_trace_hi;
        verdict.trace_id_lower = acc_trace_lo;
        verdict.span_id        = acc_span;
        verdict.trace_flags    = acc_flags;
      end
      clear_parse_state();
    end
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatches++;
    if (mismatches <= PRINT_LIMIT)
      $display("%0t: verdict %0d %s: got %h, want %h", $realtime, verdicts_seen, what,
               got, want);
  endtask

  function automatic logic [7:0] hex_char(input int unsigned nib);
    return (nib < 10) ? 8'(CHAR_ZERO + nib) : 8'("a" + nib - 10);
  endfunction

  task automatic append_char(input logic [7:0] c);
    draft.insert(draft.size(), c);
  endtask

  task automatic queue_draft(input bit pinned, input err_code_t code);
    row_verdict_t fixed;
    in_item_t     it;
    for (int i = 0; i < draft.size(); i++) begin
      it.data_byte = draft[i];
      it.last_byte = (i == draft.size() - 1);
      header_bytes.insert(header_bytes.size(), it);
    end
    fixed = '0;
    fixed.pinned = pinned;
    fixed.verdict.error_code = code;
    fixed_verdicts.insert(fixed_verdicts.size(), fixed);
    bytes_queued += draft.size();
    headers_queued++;
  endtask

  task automatic draft_well_formed();
    int shape;
    shape = $urandom_range(0, 11);
    draft.delete();
    append_char(CHAR_ZERO);
    append_char(CHAR_ZERO);
    append_char(CHAR_DASH);
    for (int i = 0; i < 32; i++) begin
      if (shape == 0) append_char(CHAR_ZERO);
      else if (shape == 2 && $urandom_range(0, 7) != 0) append_char(CHAR_ZERO);
      else append_char(hex_char($urandom_range(0, 15)));
    end
    append_char(CHAR_DASH);
    for (int i = 0; i < 16; i++) begin
      if (shape == 1) append_char(CHAR_ZERO);
      else if (shape == 2 && $urandom_range(0, 7) != 0) append_char(CHAR_ZERO);
      else append_char(hex_char($urandom_range(0, 15)));
    end
    append_char(CHAR_DASH);
    append_char(hex_char($urandom_range(0, 15)));
    append_char(hex_char($urandom_range(0, 15)));
  endtask

  task automatic draft_random_header();
    int kind;
    int p;
    int n;
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      draft.delete();
      n = $urandom_range(1, 70);
      repeat (n) append_char(8'($urandom_range(0, 255)));
    end else begin
      draft_well_formed();
      if (kind >= 67) begin
        repeat ($urandom_range(1, 3)) begin
          p = $urandom_range(0, draft.size() - 1);
          case (damage_t'($urandom_range(0, 5)))
            FLIP_RANDOM: draft[p] = 8'($urandom_range(0, 255));
            FLIP_UPPER:  draft[p] = 8'("A" + $urandom_range(0, 5));
            FLIP_DASH:   draft[p] = CHAR_DASH;
            FLIP_ZERO:   draft[p] = (draft[p] == CHAR_ZERO) ? 8'("1") : CHAR_ZERO;
            CUT_SHORT: begin
              n = $urandom_range(1, 54);
              while (draft.size() > n) void'(draft.pop_back());
            end
            default: repeat ($urandom_range(1, 9)) append_char(hex_char($urandom_range(0, 15)));
          endcase
        end
      end
    end
  endtask

  task automatic wait_drained();
    while (bytes_taken != bytes_queued || predicted_verdicts.size() != 0) @(posedge clk);
  endtask

  // sender: bursts of random length with random gaps
  always @(posedge clk) begin : sender
    int burst_left;
    int gap_left;
    if (rst) begin
      hdr_valid <= 1'b0;
      burst_left = $urandom_range(1, 60);
      gap_left   = 0;
    end else if (!hdr_valid || hdr_ready) begin
      if (gap_left > 0) begin
        gap_left--;
        hdr_valid <= 1'b0;
      end else if (header_bytes.size() > 0) begin
        hdr_item  <= header_bytes.pop_front();
        hdr_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 60);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left--;
        end
      end else begin
        hdr_valid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern in phases, plus one long hold-off on request
  initial begin : receiver
    int phase_left;
    int mode;
    phase_left = 0;
    mode = 0;
    forever begin
      @(posedge clk);
      if (stall_request && !stall_served) begin
        res_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        stall_served = 1'b1;
      end else begin
        if (phase_left == 0) begin
          mode = $urandom_range(0, 3);
          phase_left = $urandom_range(20, 200);
        end
        phase_left--;
        case (mode)
          0:       res_ready <= 1'b1;
          1:       res_ready <= ($urandom_range(0, 1) == 1);
          2:       res_ready <= ($urandom_range(0, 3) == 0);
          default: res_ready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  // predict on accepted bytes, check accepted verdicts, watch for a hang
  always @(posedge clk) begin : monitor
    bit           done;
    out_item_t    verdict;
    out_item_t    want;
    row_verdict_t fixed;
    if (!rst) begin
      if (hdr_valid && hdr_ready) begin
        bytes_taken++;
        parse_char(hdr_item, done, verdict);
        if (done) begin
          fixed = fixed_verdicts.pop_front();
          predicted_verdicts.insert(predicted_verdicts.size(),
                                    fixed.pinned ? fixed.verdict : verdict);
        end
      end
      if (res_valid && res_ready) begin
        verdicts_seen++;
        code_hits[res_item.error_code]++;
        if (predicted_verdicts.size() == 0) begin
          report_mismatch("arrived with nothing expected", 64'(res_item.error_code), '0);
        end else begin
          want = predicted_verdicts.pop_front();
          if (res_item.header_ok !== want.header_ok)
            report_mismatch("header_ok", 64'(res_item.header_ok), 64'(want.header_ok));
          if (res_item.error_code !== want.error_code)
            report_mismatch("error_code", 64'(res_item.error_code), 64'(want.error_code));
          if (res_item.trace_id_upper !== want.trace_id_upper)
            report_mismatch("trace_id_upper", res_item.trace_id_upper, want.trace_id_upper);
          if (res_item.trace_id_lower !== want.trace_id_lower)
            report_mismatch("trace_id_lower", res_item.trace_id_lower, want.trace_id_lower);
          if (res_item.span_id !== want.span_id)
            report_mismatch("span_id", res_item.span_id, want.span_id);
          if (res_item.trace_flags !== want.trace_flags)
            report_mismatch("trace_flags", 64'(res_item.trace_flags), 64'(want.trace_flags));
        end
      end
      if ((hdr_valid && hdr_ready) || (res_valid && res_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no item moved for %0d cycles, %0d verdicts outstanding", $realtime,
                 idle_cycles, predicted_verdicts.size());
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int rand_bytes;
    int rand_headers;
    clear_parse_state();
    rand_bytes = 0;
    rand_headers = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < DIR_ROWS; r++) begin
      draft.delete();
      for (int i = 0; i < dir_text[r].len(); i++) append_char(dir_text[r][i]);
      queue_draft(dir_pinned[r], dir_code[r]);
    end
    wait_drained();

    while (rand_bytes < RAND_BYTES || rand_headers < RAND_HEADERS) begin
      draft_random_header();
      rand_bytes += draft.size();
      rand_headers++;
      queue_draft(1'b0, ERR_OK);
      if (rand_headers == RAND_HEADERS / 2) begin
        // quiet point, then fill the block with short headers behind a stalled output
        wait_drained();
        stall_request = 1'b1;
        repeat (SHORT_HEADERS) begin
          draft.delete();
          repeat ($urandom_range(1, 3)) append_char(8'($urandom_range(0, 255)));
          queue_draft(1'b0, ERR_OK);
        end
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("sent %0d header bytes in %0d headers, checked %0d verdicts", bytes_queued,
             headers_queued, verdicts_seen);
    $display("verdict codes: ok %0d length %0d dash %0d version %0d hex %0d ztrace %0d zspan %0d",
             code_hits[ERR_OK], code_hits[ERR_LENGTH], code_hits[ERR_DASH],
             code_hits[ERR_VERSION], code_hits[ERR_HEX], code_hits[ERR_ZERO_TRACE],
             code_hits[ERR_ZERO_SPAN]);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
